### hdl/adll_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adll_pkg
// Types, codes and the control store shared by the array-based doubly linked
// list block.
// ----------------------------------------------------------------------------
package adll_pkg;

  // Default number of node slots, sentinel included
  localparam int DLL_NODES = 1024;

  // Request codes
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INS_BEFORE = 3'd2,
    REQ_INS_AFTER  = 3'd3,
    REQ_QRY_PREV   = 3'd4,
    REQ_QRY_NEXT   = 3'd5,
    REQ_DELETE     = 3'd6,
    REQ_UNUSED     = 3'd7
  } req_kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_NULL   = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  // Input word
  typedef struct packed {
    logic [2:0] req_type;
    logic [9:0] node;
    logic [9:0] anchor;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0] status;
    logic [9:0] neighbor;
  } out_word_t;

  // Microprogram steps
  typedef enum logic [3:0] {
    S_ERR,
    S_PF0,
    S_PB0,
    S_PB1,
    S_IB0,
    S_IB1,
    S_IA0,
    S_IA1,
    S_LINK1,
    S_LINK2,
    S_QP0,
    S_QP1,
    S_QN0,
    S_QN1,
    S_DEL0,
    S_DEL1
  } step_t;

  // Read address source, shared by all three stores
  typedef enum logic [1:0] {
    RS_ZERO,
    RS_ID,
    RS_ANC,
    RS_PREV_RD
  } rd_sel_t;

  // Insert point register load
  typedef enum logic [1:0] {
    AT_HOLD,
    AT_ZERO,
    AT_ANC,
    AT_PREV_RD
  } at_sel_t;

  // Previous-link write: prev[id]=at, prev[fol]=id, prev[next_rd]=prev_rd
  typedef enum logic [1:0] {
    PW_NONE,
    PW_ID_AT,
    PW_FOL_ID,
    PW_DEL
  } prev_wr_t;

  // Next-link write: next[id]=next_rd, next[at]=id, next[prev_rd]=next_rd
  typedef enum logic [1:0] {
    NW_NONE,
    NW_ID_FOL,
    NW_AT_ID,
    NW_DEL
  } next_wr_t;

  // Present flag write at the request node
  typedef enum logic [1:0] {
    PR_NONE,
    PR_SET,
    PR_CLR,
    PR_RSVD
  } pres_wr_t;

  // Jump-to-error condition
  typedef enum logic [1:0] {
    C_NONE,
    C_ANC_BAD,
    C_ABSENT,
    C_RSVD
  } cond_t;

  // Result emission
  typedef enum logic [1:0] {
    EM_NONE,
    EM_ERR,
    EM_PREV,
    EM_NEXT
  } emit_t;

  // One control word
  typedef struct packed {
    rd_sel_t  rd_sel;
    at_sel_t  at_sel;
    logic     fol_ld;
    prev_wr_t prev_wr;
    next_wr_t next_wr;
    pres_wr_t pres_wr;
    cond_t    cond;
    emit_t    emit;
    logic     done;
    step_t    nxt;
  } uword_t;

  // Control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{RS_ZERO, AT_HOLD, 1'b0, PW_NONE, NW_NONE, PR_NONE, C_NONE, EM_NONE,
          1'b0, S_ERR};
    unique case (s)
      S_ERR:   begin w.emit = EM_ERR; w.done = 1'b1; end
      // push front: insert point is the sentinel
      S_PF0:   begin w.at_sel = AT_ZERO; w.nxt = S_LINK1; end
      // push back: insert point is prev[0]
      S_PB0:   begin w.nxt = S_PB1; end
      S_PB1:   begin
        w.rd_sel = RS_PREV_RD; w.at_sel = AT_PREV_RD; w.nxt = S_LINK1;
      end
      // insert before anchor: insert point is prev[anchor]
      S_IB0:   begin w.rd_sel = RS_ANC; w.cond = C_ANC_BAD; w.nxt = S_IB1; end
      S_IB1:   begin
        w.rd_sel = RS_PREV_RD; w.at_sel = AT_PREV_RD; w.cond = C_ABSENT;
        w.nxt = S_LINK1;
      end
      // insert after anchor
      S_IA0:   begin
        w.rd_sel = RS_ANC; w.at_sel = AT_ANC; w.cond = C_ANC_BAD; w.nxt = S_IA1;
      end
      S_IA1:   begin w.rd_sel = RS_ANC; w.cond = C_ABSENT; w.nxt = S_LINK1; end
      // link node after the insert point; next[at] is on the read port
      S_LINK1: begin
        w.fol_ld = 1'b1; w.prev_wr = PW_ID_AT; w.next_wr = NW_ID_FOL;
        w.pres_wr = PR_SET; w.nxt = S_LINK2;
      end
      S_LINK2: begin w.prev_wr = PW_FOL_ID; w.next_wr = NW_AT_ID; w.done = 1'b1; end
      // queries
      S_QP0:   begin w.rd_sel = RS_ID; w.nxt = S_QP1; end
      S_QP1:   begin w.cond = C_ABSENT; w.emit = EM_PREV; w.done = 1'b1; end
      S_QN0:   begin w.rd_sel = RS_ID; w.nxt = S_QN1; end
      S_QN1:   begin w.cond = C_ABSENT; w.emit = EM_NEXT; w.done = 1'b1; end
      // delete
      S_DEL0:  begin w.rd_sel = RS_ID; w.nxt = S_DEL1; end
      S_DEL1:  begin
        w.cond = C_ABSENT; w.prev_wr = PW_DEL; w.next_wr = NW_DEL;
        w.pres_wr = PR_CLR; w.done = 1'b1;
      end
      default: w.done = 1'b1;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### hdl/array_doubly_linked_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// array_doubly_linked_list
// Circular doubly linked list of node ids with sentinel node 0, kept in
// previous-link, next-link and present-flag RAMs, run by a microprogram.
// ----------------------------------------------------------------------------
// After reset the block sweeps all NODES entries of its RAMs (busy high)
// before it takes the first request. A request is taken when start is
// high and busy low; busy then stays high while the microprogram runs, one
// control step per cycle, and the next request can be taken in the cycle
// after the last step. A request rejected at entry runs the error step
// only; a query or delete reads its node, then checks it; an insert finds
// its insert point, then links the node. A query or delete whose node is
// not present, or an insert before/after whose anchor is out of range or
// not present, ends in the error step instead. The steps follow the chain
// of dependent reads through the registered-read link RAMs. Queries and
// errors give one result word on out_word with out_valid high for exactly
// one cycle; the receiver must take it then, it cannot hold the block off.
// ----------------------------------------------------------------------------
module array_doubly_linked_list
  import adll_pkg::*;
#(
  parameter int NODES = DLL_NODES
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  output out_word_t      out_word
);

  localparam int AW    = $clog2(NODES);
  localparam int CMP_W = 21;
  localparam logic [CMP_W-1:0] NODES_C = CMP_W'(NODES);
  localparam logic [AW-1:0]    LAST_A  = AW'(NODES - 1);

  // sequencer and request registers
  logic             busy_r;
  step_t            step_r, step_nxt;
  logic [9:0]       id_r, anc_r;
  logic [AW-1:0]    at_r, fol_r;
  logic             clr_r;
  logic [AW-1:0]    clr_cnt_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  // RAM ports
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] prev_rd, next_rd;
  logic          pres_rd;
  logic          prev_we, next_we, pres_we;
  logic [AW-1:0] prev_wa, prev_wd, next_wa, next_wd, pres_wa;
  logic          pres_wd;

  uword_t        uw;
  logic          cond_hit, go, accept, node_bad, anc_bad;
  step_t         entry;
  logic [AW+9:0] id_ext, anc_ext;
  logic [AW-1:0] id_a, anc_a;
  logic [AW-1:0] nb;
  logic [AW+9:0] nb_ext;

  assign id_ext  = {{AW{1'b0}}, id_r};
  assign anc_ext = {{AW{1'b0}}, anc_r};
  assign id_a    = id_ext[AW-1:0];
  assign anc_a   = anc_ext[AW-1:0];

  assign busy   = busy_r | clr_r;
  assign accept = start & ~busy;

  assign uw       = ucode(step_r);
  assign anc_bad  = {{(CMP_W-10){1'b0}}, anc_r} >= NODES_C;
  assign node_bad = ({{(CMP_W-10){1'b0}}, in_word.node} >= NODES_C)
                    || (in_word.node == 10'd0);
  assign cond_hit = ((uw.cond == C_ANC_BAD) && anc_bad)
                    || ((uw.cond == C_ABSENT) && !pres_rd);
  assign go       = busy_r & ~cond_hit;

  // entry point of the microprogram
  always_comb begin
    if (node_bad) begin
      entry = S_ERR;
    end else begin
      unique case (req_kind_t'(in_word.req_type))
        REQ_PUSH_FRONT: entry = S_PF0;
        REQ_PUSH_BACK:  entry = S_PB0;
        REQ_INS_BEFORE: entry = S_IB0;
        REQ_INS_AFTER:  entry = S_IA0;
        REQ_QRY_PREV:   entry = S_QP0;
        REQ_QRY_NEXT:   entry = S_QN0;
        REQ_DELETE:     entry = S_DEL0;
        default:        entry = S_ERR;
      endcase
    end
  end

  // next step
  always_comb begin
    if (accept) begin
      step_nxt = entry;
    end else if (busy_r && cond_hit) begin
      step_nxt = S_ERR;
    end else begin
      step_nxt = uw.nxt;
    end
  end

  // read address
  always_comb begin
    case (uw.rd_sel)
      RS_ZERO:    rd_addr = '0;
      RS_ID:      rd_addr = id_a;
      RS_ANC:     rd_addr = anc_a;
      RS_PREV_RD: rd_addr = prev_rd;
      default:    rd_addr = '0;
    endcase
  end

  // write ports; the clearing sweep overrides
  always_comb begin
    prev_we = 1'b0; prev_wa = id_a;    prev_wd = at_r;
    next_we = 1'b0; next_wa = id_a;    next_wd = next_rd;
    pres_we = 1'b0; pres_wa = id_a;    pres_wd = 1'b0;
    if (clr_r) begin
      prev_we = 1'b1; prev_wa = clr_cnt_r; prev_wd = '0;
      next_we = 1'b1; next_wa = clr_cnt_r; next_wd = '0;
      pres_we = 1'b1; pres_wa = clr_cnt_r; pres_wd = (clr_cnt_r == '0);
    end else if (go) begin
      case (uw.prev_wr)
        PW_ID_AT:  begin prev_we = 1'b1; prev_wa = id_a;    prev_wd = at_r;    end
        PW_FOL_ID: begin prev_we = 1'b1; prev_wa = fol_r;   prev_wd = id_a;    end
        PW_DEL:    begin prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd; end
        default:   prev_we = 1'b0;
      endcase
      case (uw.next_wr)
        NW_ID_FOL: begin next_we = 1'b1; next_wa = id_a;    next_wd = next_rd; end
        NW_AT_ID:  begin next_we = 1'b1; next_wa = at_r;    next_wd = id_a;    end
        NW_DEL:    begin next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd; end
        default:   next_we = 1'b0;
      endcase
      case (uw.pres_wr)
        PR_SET:  begin pres_we = 1'b1; pres_wd = 1'b1; end
        PR_CLR:  begin pres_we = 1'b1; pres_wd = 1'b0; end
        default: pres_we = 1'b0;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= S_ERR;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_A) begin
          clr_r <= 1'b0;
        end
      end
      step_r      <= step_nxt;
      out_valid_r <= go && (uw.emit != EM_NONE);
      if (accept) begin
        busy_r <= 1'b1;
      end else if (go && uw.done) begin
        busy_r <= 1'b0;
      end
    end
  end

  // neighbor for queries
  assign nb     = (uw.emit == EM_PREV) ? prev_rd : next_rd;
  assign nb_ext = {10'd0, nb};

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      id_r  <= in_word.node;
      anc_r <= in_word.anchor;
    end
    if (go) begin
      case (uw.at_sel)
        AT_ZERO:    at_r <= '0;
        AT_ANC:     at_r <= anc_a;
        AT_PREV_RD: at_r <= prev_rd;
        default:    at_r <= at_r;
      endcase
      if (uw.fol_ld) begin
        fol_r <= next_rd;
      end
      case (uw.emit)
        EM_ERR: begin
          out_word_r.status   <= ST_ABSENT;
          out_word_r.neighbor <= 10'd0;
        end
        EM_PREV, EM_NEXT: begin
          out_word_r.status   <= (nb == '0) ? ST_NULL : ST_OK;
          out_word_r.neighbor <= nb_ext[9:0];
        end
        default: out_word_r <= out_word_r;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // link and flag stores
  adll_ram #(.WIDTH(AW), .DEPTH(NODES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_wa),
    .wdata (prev_wd),
    .raddr (rd_addr),
    .rdata (prev_rd)
  );

  adll_ram #(.WIDTH(AW), .DEPTH(NODES)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_wa),
    .wdata (next_wd),
    .raddr (rd_addr),
    .rdata (next_rd)
  );

  adll_ram #(.WIDTH(1), .DEPTH(NODES)) u_pres_ram (
    .clk   (clk),
    .we    (pres_we),
    .waddr (pres_wa),
    .wdata (pres_wd),
    .raddr (rd_addr),
    .rdata (pres_rd)
  );

endmodule
`default_nettype wire

### hdl/adll_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adll_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module adll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
